// ----- design/mh_pkg.sv -----
// shared types, widths and constants for the magnetometer heading block
// no dependencies; imported by every module of the block
package mh_pkg;

    // internal datapath widths
    localparam int XY_W     = 20;   // cordic vector components, signed
    localparam int Z_W      = 25;   // cordic angle accumulator, q16 degrees, signed
    localparam int HQ_W     = 26;   // q16 heading before rounding, unsigned
    localparam int Q_FRAC   = 16;   // fraction bits of internal angles
    localparam int TABLE_LEN = 24;  // entries in the arctangent table

    // request queue between front and back
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;

    // q16 angle constants
    localparam logic [HQ_W-1:0] B90_Q16  = HQ_W'(90 * 65536);
    localparam logic [HQ_W-1:0] B270_Q16 = HQ_W'(270 * 65536);
    localparam logic signed [Z_W-1:0] MAX_A_Q16 = Z_W'(90 * 65536);

    // one classified reading
    typedef struct packed {
        logic signed [15:0] x_value;
        logic signed [15:0] y_value;
        logic signed [15:0] z_value;
        logic [15:0]        ax;
        logic [15:0]        ay;
        logic               x_zero;
        logic               y_zero;
        logic               y_pos;
        logic               x_neg;
        logic               same_sign;
    } mh_item_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } mh_qstat_t;

    // atan(2^-i) in degrees, q16, rounded to nearest
    function automatic logic [23:0] atan_q16(input logic [4:0] idx);
        logic [23:0] t;
        case (idx)
            5'd0:  t = 24'd2949120;
            5'd1:  t = 24'd1740967;
            5'd2:  t = 24'd919879;
            5'd3:  t = 24'd466945;
            5'd4:  t = 24'd234379;
            5'd5:  t = 24'd117304;
            5'd6:  t = 24'd58666;
            5'd7:  t = 24'd29335;
            5'd8:  t = 24'd14668;
            5'd9:  t = 24'd7334;
            5'd10: t = 24'd3667;
            5'd11: t = 24'd1833;
            5'd12: t = 24'd917;
            5'd13: t = 24'd458;
            5'd14: t = 24'd229;
            5'd15: t = 24'd115;
            5'd16: t = 24'd57;
            5'd17: t = 24'd29;
            5'd18: t = 24'd14;
            5'd19: t = 24'd7;
            5'd20: t = 24'd4;
            5'd21: t = 24'd2;
            5'd22: t = 24'd1;
            default: t = 24'd0;
        endcase
        return t;
    endfunction

endpackage

// ----- design/mh_front.sv -----
// front end: takes a reading, assembles the axes and classifies signs
// depends on mh_pkg; feeds mh_queue
module mh_front
    import mh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  x_high,
    input  logic [7:0]  x_low,
    input  logic [7:0]  z_high,
    input  logic [7:0]  z_low,
    input  logic [7:0]  y_high,
    input  logic [7:0]  y_low,
    input  mh_qstat_t   q_status,
    output logic        push,
    output mh_item_t    push_item
);

    logic               front_valid_reg;
    logic               front_valid_next;
    mh_item_t           item_reg;
    mh_item_t           item_next;
    logic               accept;
    logic signed [15:0] x_s;
    logic signed [15:0] y_s;

    assign push     = front_valid_reg && !q_status.full;
    assign in_stall = front_valid_reg && !q_status.full ? 1'b0 : front_valid_reg;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        x_s = {x_high, x_low};
        y_s = {y_high, y_low};
        item_next.x_value   = x_s;
        item_next.y_value   = y_s;
        item_next.z_value   = {z_high, z_low};
        item_next.ax        = x_s[15] ? 16'(-x_s) : x_s;
        item_next.ay        = y_s[15] ? 16'(-y_s) : y_s;
        item_next.x_zero    = (x_s == 16'sd0);
        item_next.y_zero    = (y_s == 16'sd0);
        item_next.y_pos     = !y_s[15] && (y_s != 16'sd0);
        item_next.x_neg     = x_s[15];
        item_next.same_sign = (x_s[15] == y_s[15]);
    end

    always_comb
    begin
        if (accept)
            front_valid_next = 1'b1;
        else if (push)
            front_valid_next = 1'b0;
        else
            front_valid_next = front_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_valid_reg <= 1'b0;
        else
            front_valid_reg <= front_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item_next;
    end

    assign push_item = item_reg;

endmodule

// ----- design/mh_queue.sv -----
// short request queue between the front end and the cordic back end
// depends on mh_pkg
module mh_queue
    import mh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  mh_item_t  push_item,
    input  logic      pop,
    output mh_item_t  pop_item,
    output mh_qstat_t q_status
);

    mh_item_t            entry_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign q_status.full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign q_status.empty = (cnt_reg == '0);
    assign do_push = push && !q_status.full;
    assign do_pop  = pop && !q_status.empty;
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ----- design/mh_back.sv -----
// back end: pipelined vectoring cordic, heading assembly and output register
// depends on mh_pkg; pops from mh_queue
module mh_back
    import mh_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 4,
    parameter int CORDIC_STEPS    = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  mh_qstat_t          q_status,
    input  mh_item_t           pop_item,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [12:0]        heading,
    output logic signed [15:0] x_value,
    output logic signed [15:0] y_value,
    output logic signed [15:0] z_value
);

    localparam int NSTEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int SH     = Q_FRAC - ANGLE_FRAC_BITS;
    localparam logic [HQ_W-1:0] RND  = HQ_W'(2 ** (SH - 1));
    localparam logic [HQ_W-1:0] FULL = HQ_W'(360 * (2 ** ANGLE_FRAC_BITS));
    localparam logic [12:0] HEAD_180 = 13'(180 * (2 ** ANGLE_FRAC_BITS));

    logic advance;

    // cordic stages
    logic                  st_valid_reg [NSTEPS+1];
    logic                  st_valid_next [NSTEPS+1];
    logic signed [XY_W-1:0] px_reg [NSTEPS+1];
    logic signed [XY_W-1:0] px_next [NSTEPS+1];
    logic signed [XY_W-1:0] py_reg [NSTEPS+1];
    logic signed [XY_W-1:0] py_next [NSTEPS+1];
    logic signed [Z_W-1:0]  z_reg [NSTEPS+1];
    logic signed [Z_W-1:0]  z_next [NSTEPS+1];
    mh_item_t              it_reg [NSTEPS+1];
    mh_item_t              it_next [NSTEPS+1];

    // heading assembly stage
    logic                  hq_valid_reg, hq_valid_next;
    logic [HQ_W-1:0]       hq_reg, hq_next;
    mh_item_t              hq_item_reg;
    logic signed [Z_W-1:0] a_clamp;

    // output stage
    logic                  out_valid_reg, out_valid_next;
    logic [12:0]           heading_reg, heading_next;
    logic [HQ_W-1:0]       h_round;
    logic [HQ_W-1:0]       h_wrap;
    mh_item_t              out_item_reg;

    assign advance = !out_valid_reg || !out_stall;
    assign pop     = advance && !q_status.empty;

    always_comb
    begin
        st_valid_next[0] = pop;
        px_next[0]       = XY_W'($signed({1'b0, pop_item.ax}));
        py_next[0]       = XY_W'($signed({1'b0, pop_item.ay}));
        z_next[0]        = '0;
        it_next[0]       = pop_item;
    end

    for (genvar k = 0; k < NSTEPS; k++)
    begin : g_step
        logic signed [XY_W-1:0] dx, dy;
        logic signed [Z_W-1:0]  t;
        assign dx = py_reg[k] >>> k;
        assign dy = px_reg[k] >>> k;
        assign t  = Z_W'($signed({1'b0, atan_q16(5'(k))}));
        always_comb
        begin
            st_valid_next[k+1] = st_valid_reg[k];
            it_next[k+1]       = it_reg[k];
            if (py_reg[k] > 0)
            begin
                px_next[k+1] = px_reg[k] + dx;
                py_next[k+1] = py_reg[k] - dy;
                z_next[k+1]  = z_reg[k] + t;
            end
            else
            begin
                px_next[k+1] = px_reg[k] - dx;
                py_next[k+1] = py_reg[k] + dy;
                z_next[k+1]  = z_reg[k] - t;
            end
        end
    end

    // clamp the magnitude angle and place it about the quadrant base
    always_comb
    begin
        if (it_reg[NSTEPS].y_zero || z_reg[NSTEPS] < 0)
            a_clamp = '0;
        else if (z_reg[NSTEPS] > MAX_A_Q16)
            a_clamp = MAX_A_Q16;
        else
            a_clamp = z_reg[NSTEPS];
        if (it_reg[NSTEPS].same_sign)
            hq_next = (it_reg[NSTEPS].x_neg ? B90_Q16 : B270_Q16)
                      + HQ_W'(unsigned'(a_clamp));
        else
            hq_next = (it_reg[NSTEPS].x_neg ? B90_Q16 : B270_Q16)
                      - HQ_W'(unsigned'(a_clamp));
        hq_valid_next = st_valid_reg[NSTEPS];
    end

    // round to the output resolution and wrap a full circle; x zero gives 0 or 180 directly
    always_comb
    begin
        h_round = (hq_reg + RND) >> SH;
        h_wrap  = (h_round >= FULL) ? h_round - FULL : h_round;
        if (hq_item_reg.x_zero)
            heading_next = hq_item_reg.y_pos ? 13'd0 : HEAD_180;
        else
            heading_next = h_wrap[12:0];
        out_valid_next = advance ? hq_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NSTEPS; i++)
                st_valid_reg[i] <= 1'b0;
            hq_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                st_valid_reg <= st_valid_next;
                hq_valid_reg <= hq_valid_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            px_reg       <= px_next;
            py_reg       <= py_next;
            z_reg        <= z_next;
            it_reg       <= it_next;
            hq_reg       <= hq_next;
            hq_item_reg  <= it_reg[NSTEPS];
            heading_reg  <= heading_next;
            out_item_reg <= hq_item_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign heading   = heading_reg;
    assign x_value   = out_item_reg.x_value;
    assign y_value   = out_item_reg.y_value;
    assign z_value   = out_item_reg.z_value;

endmodule

// ----- design/magnetometer_heading.sv -----
// throughput: one request per cycle while out_stall is low, set by the fully pipelined cordic with one stage per step
// a four-entry request queue parts the front end from the cordic back end
// reset: rst_n asynchronous active low clears all valid flags, queue pointers and count
// depends on mh_pkg, mh_front, mh_queue and mh_back
module magnetometer_heading
    import mh_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 4,
    parameter int CORDIC_STEPS    = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         x_high,
    input  logic [7:0]         x_low,
    input  logic [7:0]         z_high,
    input  logic [7:0]         z_low,
    input  logic [7:0]         y_high,
    input  logic [7:0]         y_low,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [12:0]        heading,
    output logic signed [15:0] x_value,
    output logic signed [15:0] y_value,
    output logic signed [15:0] z_value
);

    // quarter-turn headings at the output resolution, used by the checks below
    localparam logic [12:0] HEAD_90  = 13'(90 * (2 ** ANGLE_FRAC_BITS));
    localparam logic [12:0] HEAD_270 = 13'(270 * (2 ** ANGLE_FRAC_BITS));

    // front end to queue
    logic      push;
    mh_item_t  push_item;
    // queue to back end
    logic      pop;
    mh_item_t  pop_item;
    mh_qstat_t q_status;

    // front end: byte assembly, absolute values and sign classes
    mh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .x_high    (x_high),
        .x_low     (x_low),
        .z_high    (z_high),
        .z_low     (z_low),
        .y_high    (y_high),
        .y_low     (y_low),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    // request queue, lets the back end stall without blocking the front end until the queue is full
    mh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_status  (q_status)
    );

    // back end: cordic pipeline, quadrant placement, rounding and wrap
    mh_back #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STEPS    (CORDIC_STEPS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .pop_item  (pop_item),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .heading   (heading),
        .x_value   (x_value),
        .y_value   (y_value),
        .z_value   (z_value)
    );

    // a request taken by the front end is always handed on before the next one
    a_front_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (push || in_stall))
        else $error("front end dropped or stalled a request incorrectly");

    // x zero with y positive points north
    a_north: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && x_value == 16'sd0 && !y_value[15] && y_value != 16'sd0)
        |-> (heading == 13'd0))
        else $error("heading wrong for x zero, y positive");

    // y zero puts the heading on the quadrant base
    a_y_axis: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && y_value == 16'sd0 && x_value != 16'sd0)
        |-> (heading == (x_value[15] ? HEAD_90 : HEAD_270)))
        else $error("heading wrong for y zero");

endmodule

// ----- dv/mh_fix_checker.sv -----
// scoreboard for magnetometer_heading: predicts each fix from the six request bytes
// and compares it with the result channel; no package or other file needed
module mh_fix_checker #(
    parameter int ANGLE_FRAC_BITS = 4,
    parameter int CORDIC_STEPS    = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [7:0]         x_high,
    input  logic [7:0]         x_low,
    input  logic [7:0]         z_high,
    input  logic [7:0]         z_low,
    input  logic [7:0]         y_high,
    input  logic [7:0]         y_low,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [12:0]        heading,
    input  logic signed [15:0] x_value,
    input  logic signed [15:0] y_value,
    input  logic signed [15:0] z_value,
    output int                 pending,
    output int                 fails
);

    localparam int ATAN_ENTRIES = 24;
    localparam int ANGLE_Q      = 16;

    typedef struct packed {
        logic [12:0]        heading;
        logic signed [15:0] x_value;
        logic signed [15:0] y_value;
        logic signed [15:0] z_value;
    } fix_t;

    fix_t fixes_due[$];
    int   fail_count = 0;

    assign fails = fail_count;

    // atan(2^-i) in degrees, q16
    function automatic longint atan_step(input int i);
        case (i)
            0:  return 2949120;
            1:  return 1740967;
            2:  return 919879;
            3:  return 466945;
            4:  return 234379;
            5:  return 117304;
            6:  return 58666;
            7:  return 29335;
            8:  return 14668;
            9:  return 7334;
            10: return 3667;
            11: return 1833;
            12: return 917;
            13: return 458;
            14: return 229;
            15: return 115;
            16: return 57;
            17: return 29;
            18: return 14;
            19: return 7;
            20: return 4;
            21: return 2;
            22: return 1;
            default: return 0;
        endcase
    endfunction

    // vectoring cordic on the first quadrant, angle in q16 degrees clamped to 0..90
    function automatic longint quadrant_angle(input longint ax, input longint ay);
        longint px;
        longint py;
        longint acc;
        longint dx;
        longint dy;
        int     steps;
        int     i;
        if (ay == 0)
            return 0;
        px    = ax;
        py    = ay;
        acc   = 0;
        steps = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
        for (i = 0; i < steps; i++)
        begin
            dx = py >>> i;
            dy = px >>> i;
            if (py > 0)
            begin
                px  += dx;
                py  -= dy;
                acc += atan_step(i);
            end
            else
            begin
                px  -= dx;
                py  += dy;
                acc -= atan_step(i);
            end
        end
        if (acc < 0)
            acc = 0;
        if (acc > (longint'(90) << ANGLE_Q))
            acc = longint'(90) << ANGLE_Q;
        return acc;
    endfunction

    function automatic fix_t predict_fix(input logic [7:0] xh, input logic [7:0] xl,
                                         input logic [7:0] zh, input logic [7:0] zl,
                                         input logic [7:0] yh, input logic [7:0] yl);
        fix_t   f;
        longint xs;
        longint ys;
        longint a;
        longint base;
        longint hq;
        longint h;
        longint full;
        int     sh;
        f.x_value = {xh, xl};
        f.y_value = {yh, yl};
        f.z_value = {zh, zl};
        xs   = longint'(f.x_value);
        ys   = longint'(f.y_value);
        full = longint'(360) << ANGLE_FRAC_BITS;
        if (xs == 0)
            h = (ys > 0) ? 0 : (longint'(180) << ANGLE_FRAC_BITS);
        else
        begin
            a    = quadrant_angle(xs < 0 ? -xs : xs, ys < 0 ? -ys : ys);
            base = (xs < 0) ? (longint'(90) << ANGLE_Q) : (longint'(270) << ANGLE_Q);
            hq   = ((xs < 0) == (ys < 0)) ? base + a : base - a;
            sh   = ANGLE_Q - ANGLE_FRAC_BITS;
            h    = (hq + (longint'(1) << (sh - 1))) >>> sh;
            if (h >= full)
                h -= full;
        end
        f.heading = 13'(h);
        return f;
    endfunction

    task automatic check_field(input string name, input longint expected, input longint actual);
        if (expected != actual)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        fix_t due;
        if (!rst_n)
        begin
            fixes_due.delete();
            pending <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                fixes_due.push_back(predict_fix(x_high, x_low, z_high, z_low, y_high, y_low));
            if (out_valid && !out_stall)
            begin
                if (fixes_due.size() == 0)
                begin
                    $error("result with no request outstanding: heading %0d", heading);
                    fail_count++;
                end
                else
                begin
                    due = fixes_due.pop_front();
                    check_field("heading", due.heading, heading);
                    check_field("x_value", due.x_value, x_value);
                    check_field("y_value", due.y_value, y_value);
                    check_field("z_value", due.z_value, z_value);
                end
            end
            pending <= fixes_due.size();
        end
    end

endmodule

// ----- dv/tb.sv -----
// top of the magnetometer heading testbench: clock, reset, request stimulus and verdict
// depends on magnetometer_heading (and its package) and on mh_fix_checker
module tb;

    localparam int FRAC_BITS   = 4;
    localparam int STEPS       = 16;
    // tail wait after the last fix, leaving slack beyond the pipeline depth
    localparam int TAIL_CYCLES = 40;
    // watchdog bound; the slowest legal run is roughly 1250 requests
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 300;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic [7:0]         x_high    = 8'h00;
    logic [7:0]         x_low     = 8'h00;
    logic [7:0]         z_high    = 8'h00;
    logic [7:0]         z_low     = 8'h00;
    logic [7:0]         y_high    = 8'h00;
    logic [7:0]         y_low     = 8'h00;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [12:0]        heading;
    logic signed [15:0] x_value;
    logic signed [15:0] y_value;
    logic signed [15:0] z_value;
    int                 pending;
    int                 fails;

    // chance out of a hundred that the sender sits idle / the receiver stalls on a cycle
    int                 idle_pct  = 0;
    int                 stall_pct = 0;
    int                 cycle_count = 0;

    magnetometer_heading #(
        .ANGLE_FRAC_BITS (FRAC_BITS),
        .CORDIC_STEPS    (STEPS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .x_high    (x_high),
        .x_low     (x_low),
        .z_high    (z_high),
        .z_low     (z_low),
        .y_high    (y_high),
        .y_low     (y_low),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .heading   (heading),
        .x_value   (x_value),
        .y_value   (y_value),
        .z_value   (z_value)
    );

    // the checker sees exactly what the block sees and predicts every fix itself
    mh_fix_checker #(
        .ANGLE_FRAC_BITS (FRAC_BITS),
        .CORDIC_STEPS    (STEPS)
    ) checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .x_high    (x_high),
        .x_low     (x_low),
        .z_high    (z_high),
        .z_low     (z_low),
        .y_high    (y_high),
        .y_low     (y_low),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .heading   (heading),
        .x_value   (x_value),
        .y_value   (y_value),
        .z_value   (z_value),
        .pending   (pending),
        .fails     (fails)
    );

    always #10 clk = ~clk;

    // receiver back-pressure, redrawn every cycle from the current phase setting
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // watchdog: a hung handshake or a lost result ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // one request: optional idle gap first, then hold the payload until it is taken
    task automatic put_request(input logic [7:0] xh, input logic [7:0] xl,
                               input logic [7:0] zh, input logic [7:0] zl,
                               input logic [7:0] yh, input logic [7:0] yl);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        x_high   <= xh;
        x_low    <= xl;
        z_high   <= zh;
        z_low    <= zl;
        y_high   <= yh;
        y_low    <= yl;
        @(posedge clk);
        // values read here are the ones the edge just sampled
        while (in_stall)
            @(posedge clk);
    endtask

    // split three signed axis values into the x, z, y byte order of the sensor
    task automatic put_axes(input logic [15:0] xv, input logic [15:0] yv, input logic [15:0] zv);
        put_request(xv[15:8], xv[7:0], zv[15:8], zv[7:0], yv[15:8], yv[7:0]);
    endtask

    // drop valid and sit until the checker holds no outstanding fix
    task automatic wait_for_fixes();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [15:0] extreme_axis();
        case ($urandom_range(6))
            0:       return 16'h0000;
            1:       return 16'h0001;
            2:       return 16'hffff;
            3:       return 16'h7fff;
            4:       return 16'h8000;
            5:       return 16'h8001;
            default: return 16'hfffe;
        endcase
    endfunction

    // mostly uniform readings, with a share aimed at the axes, the corners,
    // tiny vectors (coarse angles) and near-diagonals (rounding edges)
    task automatic put_random_reading();
        int          kind;
        logic [15:0] xv;
        logic [15:0] yv;
        logic [15:0] zv;
        kind = $urandom_range(99);
        xv   = 16'($urandom);
        yv   = 16'($urandom);
        zv   = 16'($urandom);
        if (kind < 15)
        begin
            xv = 16'(int'($urandom_range(16)) - 8);
            yv = 16'(int'($urandom_range(16)) - 8);
        end
        else if (kind < 25)
        begin
            if ($urandom_range(1))
                xv = 16'h0000;
            else
                yv = 16'h0000;
        end
        else if (kind < 38)
        begin
            xv = extreme_axis();
            yv = extreme_axis();
            if ($urandom_range(1))
                zv = extreme_axis();
        end
        else if (kind < 48)
        begin
            yv = $urandom_range(1) ? xv : -xv;
            yv = yv + 16'(int'($urandom_range(4)) - 2);
        end
        put_axes(xv, yv, zv);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed readings, back to back with no idling
        put_axes(16'h0000, 16'h0000, 16'h0000);  // both zero: x zero and y not positive
        put_axes(16'h0000, 16'h0001, 16'hffff);  // x zero, y positive
        put_axes(16'h0000, 16'hffff, 16'h7fff);  // x zero, y negative
        put_axes(16'h0000, 16'h7fff, 16'h8000);
        put_axes(16'h0000, 16'h8000, 16'h0001);
        put_axes(16'h0001, 16'h0000, 16'h0000);  // y zero: magnitude angle forced to zero, due west side
        put_axes(16'hffff, 16'h0000, 16'h0000);
        put_axes(16'h7fff, 16'h0000, 16'hffff);
        put_axes(16'h8000, 16'h0000, 16'h8000);
        put_axes(16'h0001, 16'h7fff, 16'h7fff);  // heading rounds up to full circle
        put_axes(16'h0001, 16'h8000, 16'h0000);
        put_axes(16'hffff, 16'h7fff, 16'h0000);
        put_axes(16'hffff, 16'h8000, 16'h0000);
        put_axes(16'h8000, 16'h8000, 16'hffff);  // corners of the input range
        put_axes(16'h7fff, 16'h7fff, 16'h8000);
        put_axes(16'h8000, 16'h7fff, 16'h7fff);
        put_axes(16'h7fff, 16'h8000, 16'h0001);
        put_axes(16'h0064, 16'h0064, 16'h1234);  // diagonals in each quadrant
        put_axes(16'hff9c, 16'h0064, 16'hedcb);
        put_axes(16'hff9c, 16'hff9c, 16'h00ff);
        put_axes(16'h0064, 16'hff9c, 16'hff00);
        put_axes(16'h1000, 16'h0001, 16'h5555);  // very small and nearly right magnitude angles
        put_axes(16'h0001, 16'h1000, 16'haaaa);

        // random phases: free flow, slow sender, slow receiver, both mildly slow
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 80; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 80; end
                default: begin idle_pct = 20; stall_pct = 20; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // let the pipeline empty completely once mid-run under back-pressure
                if (phase == 2 && n == PHASE_ITEMS / 2)
                    wait_for_fixes();
                put_random_reading();
            end
        end

        wait_for_fixes();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
design/mh_pkg.sv
design/mh_front.sv
design/mh_queue.sv
design/mh_back.sv
design/magnetometer_heading.sv
dv/mh_fix_checker.sv
dv/tb.sv
